### hdl/rcs_pkg.sv
// Shared types and constants for the rainbow HSV color sequencer.
// No dependencies; imported by every module of the block.
package rcs_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_STEP_INTERVAL = 2'd0;
    localparam logic [1:0] REG_SATURATION    = 2'd1;
    localparam logic [1:0] REG_BRIGHTNESS    = 2'd2;

    // Register reset values
    localparam logic [7:0] STEP_INTERVAL_RST = 8'd40;
    localparam logic [7:0] SATURATION_RST    = 8'd255;
    localparam logic [7:0] BRIGHTNESS_RST    = 8'd255;

    // Position queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // hue = wheel*255/360 = wheel*17/24; divide by 24 as >>3 then *683>>11
    localparam logic [9:0] HUE_RECIP       = 10'd683;
    localparam int         HUE_RECIP_SHIFT = 11;

    // Color conversion settings seen by the back end
    typedef struct packed {
        logic [7:0] saturation;
        logic [7:0] brightness;
    } color_cfg_t;

    // Write side of the position queue
    typedef struct packed {
        logic       push;
        logic [7:0] wheel;
    } q_push_t;

    // Status of the position queue
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### hdl/rainbow_hsv_color_sequencer.sv
// Top level of the rainbow HSV color sequencer: configuration registers,
// front end, position queue and color back end. Depends on rcs_pkg.
//
// Usage:
//   s_* carries tick words (tdata[0] = tick). A word with tick 0 is taken
//   and ignored. Each tick bumps an elapsed count; when the count exceeds
//   step_interval it clears and one RGB word is produced on m_* for the
//   current wheel position, which then steps by one and wraps at 256.
//   cfg_we/cfg_addr/cfg_wdata write step_interval (0), saturation (1) and
//   brightness (2); other indexes are ignored. Write only
//   while no color is in flight.
//   Ticks are taken one per cycle while the queue has room. The converter
//   is a four-step sequencer and takes a new position from the queue only
//   after its last color has left the final step. A four-entry position
//   queue sits between the tick counter and the converter; s_tready drops
//   only when it is full.
//   A stalled m_tready holds the output word; the converter parks its
//   finished result until the output register frees.
//   Reset clears the count, the wheel, the queue and the output valid, and
//   loads interval 40, saturation 255, brightness 255.
module rainbow_hsv_color_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] tick, [7:1] zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import rcs_pkg::*;

    logic [7:0]  step_interval_reg;
    logic [7:0]  saturation_reg;
    logic [7:0]  brightness_reg;
    color_cfg_t  color_cfg;
    q_push_t     q_wr;
    q_stat_t     q_stat;
    logic        q_pop;
    logic [7:0]  q_wheel;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_interval_reg <= STEP_INTERVAL_RST;
            saturation_reg    <= SATURATION_RST;
            brightness_reg    <= BRIGHTNESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_STEP_INTERVAL: step_interval_reg <= cfg_wdata;
                REG_SATURATION:    saturation_reg    <= cfg_wdata;
                REG_BRIGHTNESS:    brightness_reg    <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    assign color_cfg.saturation = saturation_reg;
    assign color_cfg.brightness = brightness_reg;

    rcs_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .step_interval (step_interval_reg),
        .q_stat        (q_stat),
        .q_wr          (q_wr)
    );

    rcs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .pop      (q_pop),
        .rd_wheel (q_wheel),
        .stat     (q_stat)
    );

    rcs_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (color_cfg),
        .q_stat   (q_stat),
        .q_wheel  (q_wheel),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### hdl/rcs_queue.sv
// Short FIFO of wheel positions between the tick front end and color back end.
// Depends on rcs_pkg.
module rcs_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  rcs_pkg::q_push_t wr,
    input  logic             pop,
    output logic [7:0]       rd_wheel,
    output rcs_pkg::q_stat_t stat
);
    import rcs_pkg::*;

    logic [7:0]        entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = wr.push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_wheel   = entries_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed position
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr.wheel;
        end
    end

endmodule

### hdl/rcs_front.sv
// Tick front end: counts accepted ticks and queues a wheel position per color step.
// Depends on rcs_pkg.
module rcs_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [0] tick, [7:1] zero fill
    input  logic [7:0]       step_interval,
    input  rcs_pkg::q_stat_t q_stat,
    output rcs_pkg::q_push_t q_wr
);
    import rcs_pkg::*;

    logic [8:0] elapsed_reg;
    logic [8:0] elapsed_next;
    logic [7:0] wheel_reg;
    logic [7:0] wheel_next;
    logic [8:0] elapsed_inc;
    logic       tick_word;
    logic       step;

    // Hold off ticks only while the queue has no room for a step
    assign s_tready    = !q_stat.full;
    assign tick_word   = s_tvalid && s_tready && s_tdata[0];
    assign elapsed_inc = elapsed_reg + 9'd1;
    assign step        = tick_word && (elapsed_inc > {1'b0, step_interval});

    assign q_wr.push  = step;
    assign q_wr.wheel = wheel_reg;

    // Advance the tick count; clear it and move the wheel on a step
    always_comb
    begin
        elapsed_next = elapsed_reg;
        wheel_next   = wheel_reg;
        if (step)
        begin
            elapsed_next = '0;
            wheel_next   = wheel_reg + 8'd1;
        end
        else if (tick_word)
        begin
            elapsed_next = elapsed_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            wheel_reg   <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            wheel_reg   <= wheel_next;
        end
    end

endmodule

### hdl/rcs_back.sv
// Color back end: turns a queued wheel position into an RGB word in four steps.
// Depends on rcs_pkg.
module rcs_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  rcs_pkg::color_cfg_t cfg,
    input  rcs_pkg::q_stat_t   q_stat,
    input  logic [7:0]         q_wheel,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
    import rcs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_HUE   = 2'd1;
    localparam logic [1:0] ST_TERMS = 2'd2;
    localparam logic [1:0] ST_MIX   = 2'd3;

    // Hue sectors of the six-sector conversion
    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [9:0]  n_reg;
    logic [2:0]  sector_reg;
    logic [7:0]  f_reg;
    logic [7:0]  sf_reg;
    logic [7:0]  s1f_reg;
    logic [7:0]  p_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [23:0] out_rgb_reg;

    logic [12:0] wheel17;
    logic [19:0] hue_prod;
    logic [7:0]  hue;
    logic [10:0] hue_x6;
    logic [15:0] sf_prod;
    logic [15:0] s1f_prod;
    logic [15:0] p_prod;
    logic [15:0] q_prod;
    logic [15:0] t_prod;
    logic [7:0]  q_term;
    logic [7:0]  t_term;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_stat.empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rgb_reg;

    // Step one: wheel*17, then drop three bits (the /8 part of /24)
    assign wheel17 = {1'b0, q_wheel, 4'b0000} + {5'b00000, q_wheel};

    // Step two: finish /3 by reciprocal, then split 6*hue into sector and fraction
    assign hue_prod = n_reg * HUE_RECIP;
    assign hue      = hue_prod[HUE_RECIP_SHIFT +: 8];
    assign hue_x6   = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    // Step three: saturation-scaled fractions and the p term
    assign sf_prod  = cfg.saturation * f_reg;
    assign s1f_prod = cfg.saturation * (8'd255 - f_reg);
    assign p_prod   = cfg.brightness * (8'd255 - cfg.saturation);

    // Step four: q and t terms, then sector select
    assign q_prod = cfg.brightness * (8'd255 - sf_reg);
    assign t_prod = cfg.brightness * (8'd255 - s1f_reg);
    assign q_term = q_prod[15:8];
    assign t_term = t_prod[15:8];

    always_comb
    begin
        red   = cfg.brightness;
        green = p_reg;
        blue  = q_term;
        if (cfg.saturation == 8'd0)
        begin
            green = cfg.brightness;
            blue  = cfg.brightness;
        end
        else
        begin
            case (sector_reg)
                SEC_RED_YEL:
                begin
                    red = cfg.brightness; green = t_term; blue = p_reg;
                end
                SEC_YEL_GRN:
                begin
                    red = q_term; green = cfg.brightness; blue = p_reg;
                end
                SEC_GRN_CYN:
                begin
                    red = p_reg; green = cfg.brightness; blue = t_term;
                end
                SEC_CYN_BLU:
                begin
                    red = p_reg; green = q_term; blue = cfg.brightness;
                end
                SEC_BLU_MAG:
                begin
                    red = t_term; green = p_reg; blue = cfg.brightness;
                end
                default:
                begin
                    red = cfg.brightness; green = p_reg; blue = q_term;
                end
            endcase
        end
    end

    // Sequence one position through the steps; hold in the last step until output frees
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = ST_HUE;
                end
            end
            ST_HUE:
            begin
                state_next = ST_TERMS;
            end
            ST_TERMS:
            begin
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            n_reg <= wheel17[12:3];
        end
        if (state_reg == ST_HUE)
        begin
            sector_reg <= hue_x6[10:8];
            f_reg      <= hue_x6[7:0];
        end
        if (state_reg == ST_TERMS)
        begin
            sf_reg  <= sf_prod[15:8];
            s1f_reg <= s1f_prod[15:8];
            p_reg   <= p_prod[15:8];
        end
        if ((state_reg == ST_MIX) && out_free)
        begin
            out_rgb_reg <= {blue, green, red};
        end
    end

endmodule
